// File: design/mor_pkg.sv
// Package for the two-neuron oscillator block: fixed-point constants,
// register indexes, divider request/response structs and saturation helpers.
// No dependencies.
package mor_pkg;
    localparam int FRAC_BITS   = 24;
    localparam int SUBSTEPS    = 4;
    localparam int EULER_ITERS = 4;

    localparam logic signed [63:0] QONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] STEP_FULL =
        32'((QONE + SUBSTEPS / 2) / SUBSTEPS);
    localparam logic signed [31:0] STEP_HALF =
        32'((QONE + SUBSTEPS) / (2 * SUBSTEPS));
    localparam logic signed [31:0] STEP_SIXTH =
        32'((QONE + 3 * SUBSTEPS) / (6 * SUBSTEPS));

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Register indexes.
    localparam logic [2:0] REG_TAU_RISE  = 3'd0;
    localparam logic [2:0] REG_TAU_ADAPT = 3'd1;
    localparam logic [2:0] REG_TONIC_ONE = 3'd2;
    localparam logic [2:0] REG_TONIC_TWO = 3'd3;
    localparam logic [2:0] REG_FAT_GAIN  = 3'd4;
    localparam logic [2:0] REG_MUT_GAIN  = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;

    // Divider request/response between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    function automatic logic signed [63:0] pos(input logic signed [63:0] v);
        return (v > 0) ? v : 64'sd0;
    endfunction
endpackage

// File: design/matsuoka_oscillator_rk4.sv
// Two-neuron Matsuoka oscillator with RK4 or Euler integration.
// RK4 mode: three divisions, the clamp product, then 16 evaluations of 12
// multiplies each. Euler mode: two divisions, then 4 evaluations. A new drive
// sample is taken only in idle, once the previous result has been handed to the
// output register; a held result stalls the block only once the next result is ready.
// Reset: async active low; states zero, registers at their documented defaults.
module matsuoka_oscillator_rk4
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] drive_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] osc_out,
    output logic        state_cleared
);
    // Sequencer states. A micro-op loop walks the shared multiplier.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_R1     = 4'd1;  // 2^2F / t1
    localparam logic [3:0] ST_R2     = 4'd2;  // 2^2F / t2
    localparam logic [3:0] ST_GMIN   = 4'd3;  // t1 * r2
    localparam logic [3:0] ST_CMIN   = 4'd4;  // g*2^F / (1+b)
    localparam logic [3:0] ST_MUL    = 4'd5;  // one step of the evaluation
    localparam logic [3:0] ST_WAIT   = 4'd6;  // multiplier latency
    localparam logic [3:0] ST_OUT    = 4'd7;
    localparam logic [3:0] ST_DIVW   = 4'd8;

    // Micro-op steps inside one evaluation, in issue order.
    localparam logic [3:0] OP_BV1 = 4'd0;
    localparam logic [3:0] OP_GP2 = 4'd1;
    localparam logic [3:0] OP_DX1 = 4'd2;
    localparam logic [3:0] OP_BV2 = 4'd3;
    localparam logic [3:0] OP_GP1 = 4'd4;
    localparam logic [3:0] OP_DX2 = 4'd5;
    localparam logic [3:0] OP_DV1 = 4'd6;
    localparam logic [3:0] OP_DV2 = 4'd7;
    localparam logic [3:0] OP_UP0 = 4'd8;  // trial or combine, per lane
    localparam logic [3:0] OP_UP3 = 4'd11;

    // Configuration registers.
    logic [30:0] tau_rise_reg, tau_adapt_reg, fat_gain_reg, mut_gain_reg;
    logic signed [31:0] tonic_one_reg, tonic_two_reg;
    logic mode_reg;

    // Working values.
    logic signed [31:0] st_reg [4];    // committed state x1 x2 v1 v2
    logic signed [31:0] ev_reg [4];    // point being evaluated
    logic signed [31:0] k_reg  [4];    // current derivative
    logic signed [34:0] acc_reg [4];   // k1 + 2(k2+k3), exact; k4 is added at the combine
    logic signed [31:0] bv_reg, gp_reg;
    logic signed [31:0] r1_reg, r2_reg, g_reg, c1_reg, c2_reg, drive_reg;
    logic [3:0]  state_reg;
    logic [3:0]  op_reg;
    logic [1:0]  stage_reg;            // which k of RK4
    logic [6:0]  sub_reg;
    logic        hit_reg;
    logic        div_sel_reg;
    logic signed [31:0] out_reg;
    logic        clr_reg;
    logic        out_valid_reg;

    logic signed [34:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] mul_res;
    mor_pkg::div_req_t div_req;
    mor_pkg::div_rsp_t div_rsp;

    mor_mulq u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .result(mul_res));
    mor_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic [63:0] t1_eff, t2_eff;
    assign t1_eff = (tau_rise_reg == '0) ? 64'd1 : {33'd0, tau_rise_reg};
    assign t2_eff = (tau_adapt_reg == '0) ? 64'd1 : {33'd0, tau_adapt_reg};

    logic [1:0] lane;
    assign lane = 2'(op_reg - OP_UP0);

    // The result register is free when it is empty or is being drained now.
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    logic signed [31:0] step_h;
    always_comb
    begin
        if (mode_reg || stage_reg == 2'd2)
            step_h = mor_pkg::STEP_FULL;
        else
            step_h = mor_pkg::STEP_HALF;
    end

    logic is_last;
    assign is_last = !mode_reg && stage_reg == 2'd3;

    // Multiplier operand selection. Operands stay put through ST_MUL and ST_WAIT of a
    // micro-op, so the product read in the wait state matches them.
    logic signed [63:0] n1, n2, p1, p2, pin, nin;
    always_comb
    begin
        p1  = mor_pkg::pos(64'(ev_reg[0]));
        p2  = mor_pkg::pos(64'(ev_reg[1]));
        pin = mor_pkg::pos(64'(drive_reg));
        nin = (drive_reg < 0) ? 64'(drive_reg) : 64'sd0;
        n1 = mor_pkg::sat32(64'(c1_reg) - 64'(ev_reg[0]) - 64'(bv_reg)
                            - 64'(gp_reg) - pin);
        n2 = mor_pkg::sat32(64'(c2_reg) - 64'(ev_reg[1]) - 64'(bv_reg)
                            - 64'(gp_reg) + nin);
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_GMIN)
        begin
            mul_a = 35'(t1_eff);
            mul_b = r2_reg;
        end
        else
        begin
            case (op_reg)
                OP_BV1: begin mul_a = 35'({1'b0, fat_gain_reg}); mul_b = ev_reg[2]; end
                OP_GP2: begin mul_a = 35'(g_reg); mul_b = 32'(p2); end
                OP_BV2: begin mul_a = 35'({1'b0, fat_gain_reg}); mul_b = ev_reg[3]; end
                OP_GP1: begin mul_a = 35'(g_reg); mul_b = 32'(p1); end
                OP_DX1: begin mul_a = 35'(n1); mul_b = r1_reg; end
                OP_DX2: begin mul_a = 35'(n2); mul_b = r1_reg; end
                OP_DV1: begin mul_a = 35'(mor_pkg::sat32(p1 - 64'(ev_reg[2])));
                              mul_b = r2_reg; end
                OP_DV2: begin mul_a = 35'(mor_pkg::sat32(p2 - 64'(ev_reg[3])));
                              mul_b = r2_reg; end
                default:
                begin
                    if (is_last)
                    begin
                        mul_a = acc_reg[lane] + 35'(k_reg[lane]);
                        mul_b = mor_pkg::STEP_SIXTH;
                    end
                    else
                    begin
                        mul_a = 35'(k_reg[lane]);
                        mul_b = step_h;
                    end
                end
            endcase
        end
    end

    logic signed [63:0] upd;
    assign upd = 64'(st_reg[lane]) + 64'(mul_res);

    // Clamp helpers.
    logic signed [63:0] gmin, gq;
    assign gmin = mor_pkg::sat32(mor_pkg::QONE + 64'(mul_res));

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        gq = 64'(g_reg);
        if (state_reg == ST_IDLE && in_valid)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'd1 << (2 * mor_pkg::FRAC_BITS);
            div_req.divisor  = t1_eff;
        end
        else if (state_reg == ST_R1 && div_rsp.done)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'd1 << (2 * mor_pkg::FRAC_BITS);
            div_req.divisor  = t2_eff;
        end
        else if (state_reg == ST_DIVW)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(gq) << mor_pkg::FRAC_BITS;
            div_req.divisor  = 64'(mor_pkg::QONE) + {33'd0, fat_gain_reg};
        end
    end

    function automatic logic signed [31:0] rsat(input logic [63:0] q);
        return (q > 64'd2147483647) ? 32'sh7FFFFFFF : 32'(q);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_rise_reg  <= 31'd16777216;
            tau_adapt_reg <= 31'd201326592;
            tonic_one_reg <= 32'sd16777216;
            tonic_two_reg <= 32'sd16777216;
            fat_gain_reg  <= 31'd41943040;
            mut_gain_reg  <= 31'd41943040;
            mode_reg      <= 1'b0;
            for (int i = 0; i < 4; i++) st_reg[i] <= '0;
            state_reg     <= ST_IDLE;
            op_reg        <= OP_BV1;
            stage_reg     <= '0;
            sub_reg       <= '0;
            hit_reg       <= 1'b0;
            div_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mor_pkg::REG_TAU_RISE:  tau_rise_reg  <= cfg_data[30:0];
                    mor_pkg::REG_TAU_ADAPT: tau_adapt_reg <= cfg_data[30:0];
                    mor_pkg::REG_TONIC_ONE: tonic_one_reg <= cfg_data;
                    mor_pkg::REG_TONIC_TWO: tonic_two_reg <= cfg_data;
                    mor_pkg::REG_FAT_GAIN:  fat_gain_reg  <= cfg_data[30:0];
                    mor_pkg::REG_MUT_GAIN:  mut_gain_reg  <= cfg_data[30:0];
                    mor_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            // A new result is loaded in the same cycle that the old one leaves.
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        drive_reg <= drive_in;
                        c1_reg    <= tonic_one_reg;
                        c2_reg    <= tonic_two_reg;
                        g_reg     <= 32'({1'b0, mut_gain_reg});
                        for (int i = 0; i < 4; i++) ev_reg[i] <= st_reg[i];
                        hit_reg   <= 1'b0;
                        sub_reg   <= '0;
                        stage_reg <= '0;
                        op_reg    <= OP_BV1;
                        div_sel_reg <= 1'b0;
                        state_reg <= ST_R1;
                    end
                end
                ST_R1:
                    if (div_rsp.done)
                    begin
                        r1_reg <= rsat(div_rsp.quotient);
                        state_reg <= ST_R2;
                    end
                ST_R2:
                    if (div_rsp.done)
                    begin
                        r2_reg <= rsat(div_rsp.quotient);
                        state_reg <= mode_reg ? ST_MUL : ST_GMIN;
                    end
                ST_GMIN:
                begin
                    // The product is read once the multiplier register holds it.
                    if (div_sel_reg)
                    begin
                        if (64'(g_reg) < gmin) g_reg <= 32'(gmin);
                        state_reg <= ST_DIVW;
                    end
                    div_sel_reg <= !div_sel_reg;
                end
                ST_DIVW:
                    state_reg <= ST_CMIN;
                ST_CMIN:
                    if (div_rsp.done)
                    begin
                        if (c1_reg < rsat(div_rsp.quotient))
                            c1_reg <= rsat(div_rsp.quotient);
                        if (c2_reg < rsat(div_rsp.quotient))
                            c2_reg <= rsat(div_rsp.quotient);
                        state_reg <= ST_MUL;
                    end
                ST_MUL:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    case (op_reg)
                        OP_BV1, OP_BV2: bv_reg <= mul_res;
                        OP_GP2, OP_GP1: gp_reg <= mul_res;
                        OP_DX1: k_reg[0] <= mul_res;
                        OP_DX2: k_reg[1] <= mul_res;
                        OP_DV1: k_reg[2] <= mul_res;
                        OP_DV2: k_reg[3] <= mul_res;
                        default:
                        begin
                            // Trial point or final combine for one lane.
                            ev_reg[lane] <= 32'(mor_pkg::sat32(upd));
                            if (mode_reg || is_last)
                                st_reg[lane] <= 32'(mor_pkg::sat32(upd));
                            if (is_last && mor_pkg::sat32(upd) != upd)
                                hit_reg <= 1'b1;
                            if (!mode_reg && stage_reg == 2'd0)
                                acc_reg[lane] <= 35'(k_reg[lane]);
                            else if (!mode_reg && stage_reg != 2'd3)
                                acc_reg[lane] <= acc_reg[lane]
                                                 + 35'(k_reg[lane]) * 35'sd2;
                        end
                    endcase
                    if (op_reg != OP_UP3)
                    begin
                        op_reg <= op_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        op_reg <= OP_BV1;
                        if (mode_reg || stage_reg == 2'd3)
                        begin
                            stage_reg <= '0;
                            sub_reg <= sub_reg + 7'd1;
                            if (sub_reg == 7'(mode_reg ? mor_pkg::EULER_ITERS - 1
                                                   : mor_pkg::SUBSTEPS - 1))
                                state_reg <= ST_OUT;
                            else
                                state_reg <= ST_MUL;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 2'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (hit_reg)
                        begin
                            for (int i = 0; i < 4; i++) st_reg[i] <= '0;
                            out_reg <= '0;
                        end
                        else
                            out_reg <= 32'(mor_pkg::pos(64'(st_reg[0]))
                                           - mor_pkg::pos(64'(st_reg[1])));
                        clr_reg <= hit_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // bv and gp hold the two inhibition products that feed each numerator.
    // Trial points during a stage must start from the committed state, so
    // ev is reloaded by the update step above and read in the next stage.

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign osc_out       = out_reg;
    assign state_cleared = clr_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(osc_out)) else $error("output moved");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && state_cleared) |-> (osc_out == 0)) else $error("clear out");
endmodule

// File: design/mor_divider.sv
// Unsigned restoring divider, one quotient bit per cycle, 64 by 64 bits.
// Depends on mor_pkg for the request and response structs.
module mor_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  mor_pkg::div_req_t req,
    output mor_pkg::div_rsp_t rsp
);
    logic [63:0]  quo_reg, quo_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  trial_rem;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial_rem = {rem_reg[63:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial_rem >= {1'b0, den_reg})
            begin
                rem_next = trial_rem - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial_rem;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: design/mor_mulq.sv
// Shared Q-format multiplier: registered 35x32 product, then rounding and
// saturation in the next cycle. Depends on mor_pkg.
module mor_mulq
(
    input  logic               clk,
    input  logic signed [34:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [31:0] result
);
    logic signed [66:0] prod_reg;
    logic signed [66:0] rounded;
    logic signed [63:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(op_a) * 67'(op_b);
    end

    always_comb
    begin
        rounded = prod_reg + (67'sd1 <<< (mor_pkg::FRAC_BITS - 1));
        shifted = 64'(rounded >>> mor_pkg::FRAC_BITS);
        result  = 32'(mor_pkg::sat32(shifted));
    end
endmodule

// File: test/matsuoka_oscillator_rk4_test.sv
// Self-checking bench for the two-neuron oscillator: directed and random drive
// samples and register settings, results checked against a bit-exact fixed-point predictor.
// Depends on mor_pkg and matsuoka_oscillator_rk4.
module matsuoka_oscillator_rk4_test;

    // The limit covers 1250 RK4 ticks with every output stall and every input
    // gap at its longest, taken several times over.
    localparam longint CYCLE_LIMIT  = 30000000;
    localparam int     DRAIN_CYCLES = 2000;
    localparam int     LONG_HOLD    = 6000;

    // Index past the last register; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        longint x1;
        longint x2;
        longint v1;
        longint v2;
    } neuron_pair_t;

    typedef struct {
        logic signed [31:0] osc;
        logic               cleared;
    } tick_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] drive_in;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] osc_out;
    logic        state_cleared;

    matsuoka_oscillator_rk4 dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .drive_in      (drive_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .osc_out       (osc_out),
        .state_cleared (state_cleared)
    );

    // Shadow copy of the registers and of the four oscillator states.
    logic [30:0] sh_tau_rise;
    logic [30:0] sh_tau_adapt;
    logic [31:0] sh_tonic_one;
    logic [31:0] sh_tonic_two;
    logic [30:0] sh_fatigue_gain;
    logic [30:0] sh_mutual_gain;
    logic        sh_mode;
    neuron_pair_t osc_state;

    logic signed [31:0] drive_backlog[$];
    tick_result_t       ticks_expected[$];

    int     error_count;
    int     ticks_accepted;
    int     ticks_checked;
    longint cycle_count;
    int     send_gap;
    int     recv_gap;
    int     hold_left;
    bit     hold_done;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor.
    // ------------------------------------------------------------------
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint posq(longint v);
        return (v > 0) ? v : 0;
    endfunction

    // Product of two Q values, rounded half up and saturated.
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (mor_pkg::FRAC_BITS - 1));
        return clip32(p >>> mor_pkg::FRAC_BITS);
    endfunction

    // Reciprocal of a time constant; zero acts as one LSB.
    function automatic longint qrecip(logic [30:0] t);
        longint unsigned d;
        longint unsigned q;
        d = (t == 0) ? 64'd1 : {33'd0, t};
        q = (64'd1 << (2 * mor_pkg::FRAC_BITS)) / d;
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic neuron_pair_t slope(neuron_pair_t s, longint drv, longint r1,
                                           longint r2, longint c1, longint c2,
                                           longint b, longint g);
        neuron_pair_t d;
        longint p1, p2, pin, nin, n1, n2;
        p1  = posq(s.x1);
        p2  = posq(s.x2);
        pin = posq(drv);
        nin = (drv < 0) ? drv : 0;
        n1 = clip32(c1 - s.x1 - qmul(b, s.v1) - qmul(g, p2) - pin);
        n2 = clip32(c2 - s.x2 - qmul(b, s.v2) - qmul(g, p1) + nin);
        d.x1 = qmul(n1, r1);
        d.x2 = qmul(n2, r1);
        d.v1 = qmul(clip32(p1 - s.v1), r2);
        d.v2 = qmul(clip32(p2 - s.v2), r2);
        return d;
    endfunction

    function automatic neuron_pair_t advance(neuron_pair_t s, neuron_pair_t k, longint h);
        neuron_pair_t t;
        t.x1 = clip32(s.x1 + qmul(k.x1, h));
        t.x2 = clip32(s.x2 + qmul(k.x2, h));
        t.v1 = clip32(s.v1 + qmul(k.v1, h));
        t.v2 = clip32(s.v2 + qmul(k.v2, h));
        return t;
    endfunction

    // RK4 weighted sum; the combination of slopes is exact before the product.
    function automatic longint rk_blend(longint s, longint a, longint b, longint c,
                                        longint d, longint sixth, inout bit hit);
        longint v, r;
        v = s + qmul(a + 2 * (b + c) + d, sixth);
        r = clip32(v);
        if (r != v) hit = 1'b1;
        return r;
    endfunction

    // Advances the shadow states by one tick and returns the expected result.
    function automatic tick_result_t predict_tick(logic signed [31:0] drv_raw);
        tick_result_t res;
        neuron_pair_t s, k1, k2, k3, k4, t;
        longint drv, r1, r2, c1, c2, b, g, full, half, sixth, t1, gmin, cmin;
        bit hit;
        drv   = drv_raw;
        r1    = qrecip(sh_tau_rise);
        r2    = qrecip(sh_tau_adapt);
        c1    = $signed(sh_tonic_one);
        c2    = $signed(sh_tonic_two);
        b     = sh_fatigue_gain;
        g     = sh_mutual_gain;
        full  = (mor_pkg::QONE + mor_pkg::SUBSTEPS / 2) / mor_pkg::SUBSTEPS;
        half  = (mor_pkg::QONE + mor_pkg::SUBSTEPS) / (2 * mor_pkg::SUBSTEPS);
        sixth = (mor_pkg::QONE + 3 * mor_pkg::SUBSTEPS) / (6 * mor_pkg::SUBSTEPS);
        hit   = 1'b0;
        s     = osc_state;
        res.cleared = 1'b0;
        if (sh_mode == 1'b0) begin
            // Stability clamp on the mutual gain and both tonic inputs.
            t1   = (sh_tau_rise == 0) ? 64'd1 : 64'(sh_tau_rise);
            gmin = clip32(mor_pkg::QONE + qmul(t1, r2));
            if (g < gmin) g = gmin;
            cmin = clip32((g <<< mor_pkg::FRAC_BITS) / (mor_pkg::QONE + b));
            if (c1 < cmin) c1 = cmin;
            if (c2 < cmin) c2 = cmin;
            for (int i = 0; i < mor_pkg::SUBSTEPS; i++) begin
                k1 = slope(s, drv, r1, r2, c1, c2, b, g);
                t  = advance(s, k1, half);
                k2 = slope(t, drv, r1, r2, c1, c2, b, g);
                t  = advance(s, k2, half);
                k3 = slope(t, drv, r1, r2, c1, c2, b, g);
                t  = advance(s, k3, full);
                k4 = slope(t, drv, r1, r2, c1, c2, b, g);
                s.x1 = rk_blend(s.x1, k1.x1, k2.x1, k3.x1, k4.x1, sixth, hit);
                s.x2 = rk_blend(s.x2, k1.x2, k2.x2, k3.x2, k4.x2, sixth, hit);
                s.v1 = rk_blend(s.v1, k1.v1, k2.v1, k3.v1, k4.v1, sixth, hit);
                s.v2 = rk_blend(s.v2, k1.v2, k2.v2, k3.v2, k4.v2, sixth, hit);
            end
            // A saturated final update wipes all four states.
            if (hit) begin
                s = '{0, 0, 0, 0};
                res.cleared = 1'b1;
            end
        end else begin
            for (int i = 0; i < mor_pkg::EULER_ITERS; i++) begin
                k1 = slope(s, drv, r1, r2, c1, c2, b, g);
                s  = advance(s, k1, full);
            end
        end
        osc_state = s;
        res.osc = 32'(posq(s.x1) - posq(s.x2));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Register writes, issued only while the block has nothing in flight.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mor_pkg::REG_TAU_RISE:  sh_tau_rise     = data[30:0];
            mor_pkg::REG_TAU_ADAPT: sh_tau_adapt    = data[30:0];
            mor_pkg::REG_TONIC_ONE: sh_tonic_one    = data;
            mor_pkg::REG_TONIC_TWO: sh_tonic_two    = data;
            mor_pkg::REG_FAT_GAIN:  sh_fatigue_gain = data[30:0];
            mor_pkg::REG_MUT_GAIN:  sh_mutual_gain  = data[30:0];
            mor_pkg::REG_MODE:      sh_mode         = data[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] tr, logic [31:0] ta, logic [31:0] c1,
                             logic [31:0] c2, logic [31:0] b, logic [31:0] g,
                             logic [31:0] mode);
        write_reg(mor_pkg::REG_TAU_RISE, tr);
        write_reg(mor_pkg::REG_TAU_ADAPT, ta);
        write_reg(mor_pkg::REG_TONIC_ONE, c1);
        write_reg(mor_pkg::REG_TONIC_TWO, c2);
        write_reg(mor_pkg::REG_FAT_GAIN, b);
        write_reg(mor_pkg::REG_MUT_GAIN, g);
        write_reg(mor_pkg::REG_MODE, mode);
    endtask

    // Waits until every queued sample has been sent and every result seen.
    task automatic wait_idle();
        while (drive_backlog.size() != 0 || in_valid || ticks_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly musical drive levels, some larger, some raw and some extremes.
    function automatic logic [31:0] pick_drive();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        if (sel < 78) return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
        if (sel < 92) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Time constants mostly between a quarter and sixteen, sometimes anything.
    function automatic logic [31:0] pick_tau();
        if ($urandom_range(0, 9) < 8) return $urandom_range(32'h0040_0000, 32'h1000_0000);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_gain();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 32'h0800_0000);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_tonic();
        if ($urandom_range(0, 9) < 8)
            return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        return $urandom;
    endfunction

    task automatic queue_random(int count);
        repeat (count) drive_backlog.push_back(pick_drive());
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] directed[$];
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        sh_tau_rise     = 31'd16777216;
        sh_tau_adapt    = 31'd201326592;
        sh_tonic_one    = 32'd16777216;
        sh_tonic_two    = 32'd16777216;
        sh_fatigue_gain = 31'd41943040;
        sh_mutual_gain  = 31'd41943040;
        sh_mode         = 1'b0;
        osc_state       = '{0, 0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples at the reset settings: zero, both extremes, single
        // LSBs, unity levels and a sustained one-sided drive.
        directed = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                     32'h0100_0000, 32'hFF00_0000, 32'h0200_0000, 32'h0200_0000,
                     32'hFE00_0000, 32'h0, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (directed[i]) drive_backlog.push_back(directed[i]);
        wait_idle();

        // Euler mode at the reset settings: no clamp and no clearing.
        write_reg(mor_pkg::REG_MODE, 32'h1);
        foreach (directed[i]) drive_backlog.push_back(directed[i]);
        wait_idle();

        // Zero time constants act as one LSB; the huge reciprocals saturate
        // the states and force clears in RK4 mode. The write past the last
        // register must change nothing.
        write_all(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 32'h0280_0000,
                  32'h0280_0000, 32'h0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        queue_random(40);
        wait_idle();

        // Largest time constants and gains with the most negative tonic.
        write_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        queue_random(60);
        wait_idle();

        // Euler with the fastest response, full tonic and no inhibition.
        write_all(32'h1, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        queue_random(60);
        wait_idle();

        // Back to the reset values: a long run of ordinary oscillation. The
        // output side holds off for a long stretch somewhere in here.
        write_all(32'd16777216, 32'd201326592, 32'd16777216, 32'd16777216,
                  32'd41943040, 32'd41943040, 32'h0);
        queue_random(250);
        wait_idle();

        // Random settings, mostly in a musical range.
        for (int p = 0; p < 8; p++) begin
            write_all(pick_tau(), pick_tau(), pick_tonic(), pick_tonic(),
                      pick_gain(), pick_gain(), {$urandom_range(0, 1) == 1 ? 32'h1 : 32'h0});
            queue_random(100);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && ticks_expected.size() == 0)
            $display("[matsuoka_oscillator_rk4] OK");
        else
            $display("[matsuoka_oscillator_rk4] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: presents queued samples with random gaps. Each accepted
    // transfer advances the predictor and queues the expected result.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            drive_in       <= '0;
            send_gap       <= 0;
            ticks_accepted <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                ticks_expected.push_back(predict_tick(drive_in));
                ticks_accepted <= ticks_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (drive_backlog.size() != 0)
                begin
                    in_valid <= 1'b1;
                    drive_in <= drive_backlog.pop_front();
                    // Mostly back to back, sometimes a short gap, rarely long.
                    case ($urandom_range(0, 9))
                        0, 1, 2: send_gap <= $urandom_range(1, 4);
                        3:       send_gap <= $urandom_range(100, 1500);
                        default: send_gap <= 0;
                    endcase
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long output hold-off, started once enough ticks have been accepted
    // that the input side keeps offering samples throughout it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && ticks_accepted >= 200)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each result transfer against the oldest
    // expectation and stalls the output at random.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on tick %0d: %s got %h expected %h", ticks_checked, what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            recv_gap      <= 0;
            ticks_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (ticks_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", osc_out, 32'h0);
                end
                else
                begin
                    want = ticks_expected.pop_front();
                    if (osc_out !== want.osc)
                        report_mismatch("osc_out", osc_out, want.osc);
                    if (state_cleared !== want.cleared)
                        report_mismatch("state_cleared", 32'(state_cleared),
                                        32'(want.cleared));
                end
                ticks_checked <= ticks_checked + 1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: recv_gap <= $urandom_range(1, 5);
                    4:          recv_gap <= $urandom_range(100, 2000);
                    default:    recv_gap <= 0;
                endcase
            end
        end
    end

    initial error_count = 0;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[matsuoka_oscillator_rk4] ERROR");
            $finish;
        end
    end

    initial cycle_count = 0;
endmodule

// File: filelist.f
design/mor_pkg.sv
design/mor_divider.sv
design/mor_mulq.sv
design/matsuoka_oscillator_rk4.sv
test/matsuoka_oscillator_rk4_test.sv
